FILE: src/fpda_pkg.sv
package fpda_pkg;

    // character codes
    localparam logic [6:0] FPDA_CH_ZERO  = 7'h30;
    localparam logic [6:0] FPDA_CH_POINT = 7'h2E;
    localparam logic [6:0] FPDA_CH_MINUS = 7'h2D;

    // configuration register indexes
    localparam int unsigned FPDA_CFG_IDX_W = 2;
    localparam logic [FPDA_CFG_IDX_W-1:0] FPDA_CFG_FRACTION_BITS  = 2'd0;
    localparam logic [FPDA_CFG_IDX_W-1:0] FPDA_CFG_DECIMAL_DIGITS = 2'd1;
    localparam logic [FPDA_CFG_IDX_W-1:0] FPDA_CFG_SIGNED_MODE    = 2'd2;
    localparam int unsigned FPDA_CFG_DATA_W = 4;

    localparam int unsigned FPDA_MAX_DECIMALS = 8;

    // integer part: up to five decimal digits, most significant first
    localparam int unsigned FPDA_INT_DIGITS = 5;
    localparam int unsigned FPDA_POS_W      = $clog2(FPDA_INT_DIGITS);
    localparam logic [FPDA_POS_W-1:0] FPDA_LAST_POS = FPDA_POS_W'(FPDA_INT_DIGITS - 1);

    // one classified value, handed from front to back
    typedef struct packed {
        logic        neg;
        logic [15:0] ip;
        logic [14:0] frac;
        logic [14:0] mask;
        logic [3:0]  fb;
        logic [3:0]  nd;
    } t_job;

    function automatic logic [13:0] fpda_pow10(input logic [FPDA_POS_W-1:0] pos);
        logic [13:0] v;
        case (pos)
            3'd0:    v = 14'd10000;
            3'd1:    v = 14'd1000;
            3'd2:    v = 14'd100;
            3'd3:    v = 14'd10;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

endpackage

FILE: src/fpda_if.sv
interface fpda_in_if;
    import fpda_pkg::*;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fpda_out_if;
    import fpda_pkg::*;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface fpda_cfg_if;
    import fpda_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [FPDA_CFG_IDX_W-1:0]  index;
    logic [FPDA_CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/fpda_front.sv
module fpda_front
    import fpda_pkg::*;
#(
    parameter int unsigned MAX_DECIMALS = FPDA_MAX_DECIMALS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpda_in_if.sink     i_in,
    fpda_cfg_if.sink    i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [3:0] r_fraction_bits;
    logic [3:0] r_decimal_digits;
    logic       r_signed_mode;

    logic        w_neg;
    logic [16:0] w_mag;
    logic [15:0] w_mask;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction_bits  <= 4'd0;
            r_decimal_digits <= 4'd1;
            r_signed_mode    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                FPDA_CFG_FRACTION_BITS:  r_fraction_bits  <= i_cfg.data;
                FPDA_CFG_DECIMAL_DIGITS: r_decimal_digits <= i_cfg.data;
                FPDA_CFG_SIGNED_MODE:    r_signed_mode    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // sign, magnitude and split into integer and fraction parts
    always_comb begin
        w_neg  = r_signed_mode & i_in.value[15];
        w_mag  = w_neg ? (17'h10000 - {1'b0, i_in.value}) : {1'b0, i_in.value};
        w_mask = (16'd1 << r_fraction_bits) - 16'd1;
        o_job.neg  = w_neg;
        o_job.ip   = 16'(w_mag >> r_fraction_bits);
        o_job.frac = w_mag[14:0] & w_mask[14:0];
        o_job.mask = w_mask[14:0];
        o_job.fb   = r_fraction_bits;
        o_job.nd   = ({1'b0, r_decimal_digits} > 5'(MAX_DECIMALS)) ?
                     4'(MAX_DECIMALS) : r_decimal_digits;
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid & !i_full;

endmodule

FILE: src/fpda_queue.sv
module fpda_queue
    import fpda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_job                 r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [PTR_W:0]       r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/fpda_back.sv
module fpda_back
    import fpda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    fpda_out_if.source  o_out
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SIGN  = 5'b00010,
        ST_INT   = 5'b00100,
        ST_POINT = 5'b01000,
        ST_FRAC  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [15:0]           r_ip, n_ip;
    logic [14:0]           r_frac, n_frac;
    logic [14:0]           r_mask, n_mask;
    logic [3:0]            r_fb, n_fb;
    logic [3:0]            r_nd, n_nd;
    logic [3:0]            r_cnt, n_cnt;
    logic [FPDA_POS_W-1:0] r_pos, n_pos;
    logic                  r_started, n_started;
    logic                  r_out_valid, n_out_valid;
    logic [6:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic        w_can_emit;
    logic [13:0] w_pow;
    logic [17:0] w_multiple;
    logic [3:0]  w_idigit;
    logic [15:0] w_irem;
    logic [18:0] w_prod;
    logic [3:0]  w_fdigit;
    logic        w_frac_last;

    assign w_can_emit = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == ST_IDLE) && i_valid;

    // integer digit: compare against the nine multiples of the current power of ten
    always_comb begin
        w_pow    = fpda_pow10(r_pos);
        w_idigit = 4'd0;
        w_irem   = r_ip;
        w_multiple = '0;
        for (int k = 1; k <= 9; k++) begin
            w_multiple = 18'(w_pow) * 18'(k);
            if ({2'b00, r_ip} >= w_multiple) begin
                w_idigit = 4'(k);
                w_irem   = 16'({2'b00, r_ip} - w_multiple);
            end
        end
    end

    // fraction digit: times ten, integer part out, fraction part kept
    always_comb begin
        w_prod      = 19'(r_frac) * 19'd10;
        w_fdigit    = 4'(w_prod >> r_fb);
        w_frac_last = (r_cnt == r_nd - 4'd1);
    end

    always_comb begin
        n_state     = r_state;
        n_ip        = r_ip;
        n_frac      = r_frac;
        n_mask      = r_mask;
        n_fb        = r_fb;
        n_nd        = r_nd;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_started   = r_started;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ip      = i_job.ip;
                    n_frac    = i_job.frac;
                    n_mask    = i_job.mask;
                    n_fb      = i_job.fb;
                    n_nd      = i_job.nd;
                    n_cnt     = 4'd0;
                    n_pos     = '0;
                    n_started = 1'b0;
                    n_state   = i_job.neg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = FPDA_CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_INT;
                end
            end
            ST_INT: begin
                if (w_can_emit) begin
                    // leading zeros are skipped, the units digit always printed
                    if (w_idigit != 4'd0 || r_started || r_pos == FPDA_LAST_POS) begin
                        n_out_valid = 1'b1;
                        n_out_char  = FPDA_CH_ZERO + 7'(w_idigit);
                        n_out_last  = (r_pos == FPDA_LAST_POS) && (r_nd == 4'd0);
                        n_started   = 1'b1;
                    end
                    n_ip = w_irem;
                    if (r_pos == FPDA_LAST_POS) begin
                        n_state = (r_nd == 4'd0) ? ST_IDLE : ST_POINT;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            ST_POINT: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = FPDA_CH_POINT;
                    n_out_last  = 1'b0;
                    n_state     = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = FPDA_CH_ZERO + 7'(w_fdigit);
                    n_out_last  = w_frac_last;
                    n_frac      = w_prod[14:0] & r_mask;
                    n_cnt       = r_cnt + 4'd1;
                    if (w_frac_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ip       <= n_ip;
        r_frac     <= n_frac;
        r_mask     <= n_mask;
        r_fb       <= n_fb;
        r_nd       <= n_nd;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_started  <= n_started;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char == FPDA_CH_MINUS || r_out_char == FPDA_CH_POINT ||
                         (r_out_char >= FPDA_CH_ZERO && r_out_char <= FPDA_CH_ZERO + 7'd9)))
        else $error("output character outside minus, point and digits");

    a_sign_point_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_char == FPDA_CH_MINUS || r_out_char == FPDA_CH_POINT))
        |-> !r_out_last)
        else $error("minus or point marked as final character");

    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAC) |-> (r_nd != 4'd0 && r_cnt < r_nd))
        else $error("fraction digit count out of range");

    a_point_follows_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POINT) |-> $past(r_state) == ST_INT || $past(r_state) == ST_POINT)
        else $error("point entered without integer part");

endmodule

FILE: src/fixed_point_to_decimal_ascii.sv
// sequencing: an accepted value passes the queue; the back-end sequencer pops it in idle
//   and then steps through the sign (if negative), all five integer positions (skipped
//   leading zeros too) and, if decimal_digits is nonzero, the point and fraction digits;
//   a character waits in the output register until taken; new values are popped in idle
// reset: synchronous, active low; config returns to fraction_bits 0, decimal_digits 1,
//   unsigned mode, and the queue and output register are emptied
module fixed_point_to_decimal_ascii
    import fpda_pkg::*;
#(
    parameter int unsigned MAX_DECIMALS = FPDA_MAX_DECIMALS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpda_in_if.sink    i_in,
    fpda_cfg_if.sink   i_cfg,
    fpda_out_if.source o_out
);

    // front to queue
    logic w_push;
    logic w_full;
    t_job w_front_job;

    // queue to back
    logic w_pop;
    logic w_job_valid;
    t_job w_back_job;

    // front: config registers, sign handling, integer / fraction split
    fpda_front #(
        .MAX_DECIMALS (MAX_DECIMALS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_front_job)
    );

    // two-entry queue lets a new value request land while text is still going out
    fpda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_back_job)
    );

    // back: character sequencer with registered output
    fpda_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_job_valid),
        .i_job   (w_back_job),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
